/* design/pulse_width_qualified_meter_bank_unit_defines.svh */
// assertion macros for the pulse width qualified meter bank
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef PULSE_WIDTH_QUALIFIED_METER_BANK_UNIT_DEFINES_SVH
`define PULSE_WIDTH_QUALIFIED_METER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PWQM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PWQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pwqm_pkg.sv */
// shared types and constants of the pulse width qualified meter bank
// no dependencies
package pwqm_pkg;

  localparam int METERS_DEFAULT = 8;
  localparam int ENABLE_BITS    = 8;
  localparam int OPCODE_W       = 2;
  localparam int INDEX_W        = 3;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 27;
  localparam int DATA_W         = 32;
  localparam int PADDR_W        = 3;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT     = COUNT_W'(99999999);
  localparam logic [TIME_W-1:0]  MIN_ON_RESET    = TIME_W'(80000);
  localparam logic [ENABLE_BITS-1:0] ENABLE_RESET = '1;

  // register indexes on the apb port
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MIN_ON = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PIN  = 2'd0,
    OP_TICK = 2'd1,
    OP_LOAD = 2'd2,
    OP_READ = 2'd3
  } opcode_e;

  // one registered command beat as seen by every meter cell
  typedef struct packed {
    logic                valid;
    opcode_e             opcode;
    logic [INDEX_W-1:0]  meter_index;
    logic                pin_level;
    logic [TIME_W-1:0]   tick_cycles;
    logic [COUNT_W-1:0]  load_value;
  } meter_cmd_t;

endpackage

/* design/pulse_width_qualified_meter_bank_unit.sv */
// path: a taken command is held in the input register, updates the meters and is loaded into
//   the result register, which drives done_o and the result beat
// throughput: one command per cycle, busy is never raised
// reset: counts, on-times, pin and energized flags clear; enable mask 0xff, min on-time 80000
// the receiver cannot stall: each result beat is shown for exactly one cycle
`include "pulse_width_qualified_meter_bank_unit_defines.svh"

module pulse_width_qualified_meter_bank_unit #(
  parameter int METERS = pwqm_pkg::METERS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pwqm_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [pwqm_pkg::INDEX_W-1:0]         meter_index_i,
  input  logic                                 pin_level_i,
  input  logic [pwqm_pkg::TIME_W-1:0]          tick_cycles_i,
  input  logic [pwqm_pkg::COUNT_W-1:0]         load_value_i,
  // result channel
  output logic                                 done_o,
  output logic [pwqm_pkg::COUNT_W-1:0]         count_value_o,
  output logic                                 any_on_o,
  // apb configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwqm_pkg::PADDR_W-1:0]         paddr,
  input  logic [pwqm_pkg::DATA_W-1:0]          pwdata,
  output logic [pwqm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import pwqm_pkg::*;

  // input register: valid is control, the payload needs no reset
  logic                  valid_q;
  logic [OPCODE_W-1:0]   opcode_q;
  logic [INDEX_W-1:0]    meter_index_q;
  logic                  pin_level_q;
  logic [TIME_W-1:0]     tick_cycles_q;
  logic [COUNT_W-1:0]    load_value_q;
  logic                  accept;

  // configuration
  logic [ENABLE_BITS-1:0] meter_enable;
  logic [TIME_W-1:0]      min_on_time;

  // per meter post-update values
  meter_cmd_t            cmd;
  logic [METERS-1:0]     meter_en;
  logic [METERS-1:0]     active_next;
  logic [COUNT_W-1:0]    count_next [METERS];
  logic [COUNT_W-1:0]    count_sel;

  // result register
  logic                  done_q;
  logic [COUNT_W-1:0]    count_value_q;
  logic                  any_on_q;

  // every meter updates in the same cycle, so a new command fits behind each one
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q      <= opcode_i;
      meter_index_q <= meter_index_i;
      pin_level_q   <= pin_level_i;
      tick_cycles_q <= tick_cycles_i;
      load_value_q  <= load_value_i;
    end
  end

  assign cmd.valid       = valid_q;
  assign cmd.opcode      = opcode_e'(opcode_q);
  assign cmd.meter_index = meter_index_q;
  assign cmd.pin_level   = pin_level_q;
  assign cmd.tick_cycles = tick_cycles_q;
  assign cmd.load_value  = load_value_q;

  pwqm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .meter_enable_o (meter_enable),
    .min_on_time_o  (min_on_time)
  );

  // meters past the enable mask width are always treated as disabled
  for (genvar g = 0; g < METERS; g++) begin : g_meter
    if (g < ENABLE_BITS) begin : g_en
      assign meter_en[g] = meter_enable[g];
    end else begin : g_dis
      assign meter_en[g] = 1'b0;
    end

    pwqm_meter #(
      .INDEX (g)
    ) u_meter (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .enable_i      (meter_en[g]),
      .min_on_time_i (min_on_time),
      .count_next_o  (count_next[g]),
      .active_next_o (active_next[g])
    );
  end

  // only the addressed meter drives a nonzero count; an index past the bank reads zero
  always_comb begin
    count_sel = '0;
    for (int m = 0; m < METERS; m++) begin
      count_sel = count_sel | count_next[m];
    end
  end

  // result register, loaded with the state as it stands after the command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      count_value_q <= count_sel;
      any_on_q      <= |active_next;
    end
  end

  assign done_o        = done_q;
  assign count_value_o = count_value_q;
  assign any_on_o      = any_on_q;

  // every taken command gives exactly one result beat, through the input and result registers
  `PWQM_ASSERT_IMPL(a_accept_done, accept, ##2 done_o, "accepted command gave no result beat")
  `PWQM_ASSERT_IMPL(a_done_accept, done_o, $past(accept, 2), "result beat without a command")
  // a load of an existing meter reads back the loaded value
  `PWQM_ASSERT_NEXT(a_load_readback,
    valid_q && (opcode_e'(opcode_q) == OP_LOAD) && (32'(meter_index_q) < METERS),
    count_value_o == $past(load_value_q), "load did not reach the addressed meter")

endmodule

/* design/pwqm_cfg.sv */
// apb configuration registers: meter enable mask and minimum on-time
// depends on pwqm_pkg
module pwqm_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwqm_pkg::PADDR_W-1:0]         paddr,
  input  logic [pwqm_pkg::DATA_W-1:0]          pwdata,
  output logic [pwqm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  output logic [pwqm_pkg::ENABLE_BITS-1:0]     meter_enable_o,
  output logic [pwqm_pkg::TIME_W-1:0]          min_on_time_o
);
  import pwqm_pkg::*;

  logic [ENABLE_BITS-1:0] meter_enable_q;
  logic [TIME_W-1:0]      min_on_time_q;
  logic                   wr_en;
  logic                   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_enable_q <= ENABLE_RESET;
      min_on_time_q  <= MIN_ON_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE: meter_enable_q <= pwdata[ENABLE_BITS-1:0];
        REG_MIN_ON: min_on_time_q  <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE: prdata = DATA_W'(meter_enable_q);
      REG_MIN_ON: prdata = DATA_W'(min_on_time_q);
      default:    prdata = '0;
    endcase
  end

  assign meter_enable_o = meter_enable_q;
  assign min_on_time_o  = min_on_time_q;

endmodule

/* design/pwqm_meter.sv */
// one meter cell: pin edge timing, qualified pulse count, saturating on-time
// depends on pwqm_pkg
module pwqm_meter #(
  parameter int INDEX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pwqm_pkg::meter_cmd_t          cmd_i,
  input  logic                          enable_i,
  input  logic [pwqm_pkg::TIME_W-1:0]   min_on_time_i,
  output logic [pwqm_pkg::COUNT_W-1:0]  count_next_o,
  output logic                          active_next_o
);
  import pwqm_pkg::*;

  logic               prev_q, prev_d;
  logic               energized_q, energized_d;
  logic [TIME_W-1:0]  on_time_q, on_time_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               hit;
  logic [TIME_W:0]    on_sum;
  logic [COUNT_W:0]   count_inc;

  assign hit       = (32'(cmd_i.meter_index) == INDEX);
  assign on_sum    = {1'b0, on_time_q} + {1'b0, cmd_i.tick_cycles};
  assign count_inc = {1'b0, count_q} + (COUNT_W+1)'(1);

  always_comb begin
    prev_d      = prev_q;
    energized_d = energized_q;
    on_time_d   = on_time_q;
    count_d     = count_q;
    if (cmd_i.valid) begin
      case (cmd_i.opcode)
        OP_PIN: begin
          if (hit) begin
            if (!enable_i) begin
              prev_d      = 1'b0;
              energized_d = 1'b0;
              on_time_d   = '0;
            end else begin
              if (cmd_i.pin_level) begin
                if (!prev_q) energized_d = 1'b1;
              end else if (prev_q) begin
                // falling edge: count only pulses strictly longer than the minimum
                if (on_time_q > min_on_time_i) begin
                  count_d = (count_inc > {1'b0, COUNT_LIMIT}) ? '0 : count_inc[COUNT_W-1:0];
                end
                on_time_d   = '0;
                energized_d = 1'b0;
              end
              prev_d = cmd_i.pin_level;
            end
          end
        end
        OP_TICK: begin
          if (enable_i && energized_q) begin
            on_time_d = on_sum[TIME_W] ? '1 : on_sum[TIME_W-1:0];
          end
        end
        OP_LOAD: begin
          if (hit) count_d = cmd_i.load_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      energized_q <= 1'b0;
      on_time_q   <= '0;
      count_q     <= '0;
    end else begin
      prev_q      <= prev_d;
      energized_q <= energized_d;
      on_time_q   <= on_time_d;
      count_q     <= count_d;
    end
  end

  // result of the addressed meter only, zero elsewhere so the top can or-reduce
  assign count_next_o  = hit ? count_d : '0;
  assign active_next_o = enable_i & energized_d;

endmodule
